// ===== design/evr_pkg.sv =====
// Shared constants, types and the arctangent table of the Euler rotation core.
package evr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int COORD_WIDTH   = 32;
    localparam int ANGLE_WIDTH   = 16;
    localparam int NUM_AXES      = 3;

    // The phase is a 32-bit binary angle, 2^32 being one full turn.
    localparam int PHASE_W      = 32;
    localparam int FRAC_BITS    = 30;
    localparam int ATAN_ENTRIES = 30;
    localparam int IDX_W        = $clog2(ATAN_ENTRIES);

    // Sine and cosine in Q2.30, phase accumulator with one guard bit.
    localparam int CS_W = 32;
    localparam int Z_W  = PHASE_W + 1;

    // Intermediate coordinates: a vector component may grow by up to root three.
    localparam int WIDE_W = COORD_WIDTH + 2;

    localparam logic [CS_W-1:0] GAIN_START = CS_W'(652032874);

    localparam int IN_BITS     = NUM_AXES * COORD_WIDTH + NUM_AXES * ANGLE_WIDTH;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = NUM_AXES * COORD_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // atan(2^-i) in units of 2^32 per turn, rounded to nearest.
    localparam logic [PHASE_W-1:0] ATAN_TURN [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef logic signed [CS_W-1:0]   cs_t;
    typedef logic signed [Z_W-1:0]    phase_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        cs_t    x;
        cs_t    y;
        phase_t z;
        logic   flip;
    } cordic_lane_t;

    typedef struct packed {
        cs_t  sin_v;
        cs_t  cos_v;
        logic flip;
    } trig_t;

    typedef struct packed {
        wide_t        [NUM_AXES-1:0] v;
        cordic_lane_t [NUM_AXES-1:0] lane;
    } cordic_item_t;

    typedef struct packed {
        wide_t [NUM_AXES-1:0] v;
        trig_t [NUM_AXES-1:0] trig;
    } turn_item_t;

endpackage

// ===== design/evr_cordic_cell.sv =====
// One CORDIC iteration applied to the three angle lanes, carrying the vector along.
module evr_cordic_cell
    import evr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [IDX_W-1:0]   stage_idx,
    input  logic               in_valid,
    output logic               in_ready,
    input  cordic_item_t       in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output cordic_item_t       out_item
);

    logic         valid_reg;
    cordic_item_t item_reg;
    cordic_item_t item_next;
    phase_t       atan_step;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign atan_step = $signed(Z_W'(ATAN_TURN[stage_idx]));

    always_comb
    begin
        item_next = in_item;
        for (int l = 0; l < NUM_AXES; l++)
        begin
            if (!in_item.lane[l].z[Z_W-1])
            begin
                item_next.lane[l].x = in_item.lane[l].x - (in_item.lane[l].y >>> stage_idx);
                item_next.lane[l].y = in_item.lane[l].y + (in_item.lane[l].x >>> stage_idx);
                item_next.lane[l].z = in_item.lane[l].z - atan_step;
            end
            else
            begin
                item_next.lane[l].x = in_item.lane[l].x + (in_item.lane[l].y >>> stage_idx);
                item_next.lane[l].y = in_item.lane[l].y - (in_item.lane[l].x >>> stage_idx);
                item_next.lane[l].z = in_item.lane[l].z + atan_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== design/evr_turn_cell.sv =====
// Two-stage plane rotation of the first two vector components by the leading angle.
module evr_turn_cell
    import evr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  turn_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output turn_item_t out_item
);

    localparam int MAG_A_W = WIDE_W;
    localparam int MAG_C_W = CS_W;
    localparam int PROD_W  = MAG_A_W + MAG_C_W;
    localparam int R_W     = PROD_W + 1 - FRAC_BITS;
    localparam int T_W     = R_W + 1;

    // Products in the order a*c, b*s, a*s, b*c.
    localparam int NUM_PROD = 4;

    // Sign-magnitude product rounded to nearest, ties away from zero.
    function automatic logic signed [T_W-1:0] round_term(input logic [PROD_W-1:0] p,
                                                          input logic neg);
        logic [PROD_W:0] biased;
        logic [R_W-1:0]  r;
        biased = {1'b0, p} + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
        r      = biased[PROD_W:FRAC_BITS];
        return neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    logic                          valid1_reg;
    logic                          valid2_reg;
    logic                          rdy1;
    logic                          rdy2;
    logic [NUM_PROD-1:0][PROD_W-1:0] prod_reg;
    logic [NUM_PROD-1:0][PROD_W-1:0] prod_next;
    logic [NUM_PROD-1:0]           neg_reg;
    logic [NUM_PROD-1:0]           neg_next;
    turn_item_t                    pass_reg;
    turn_item_t                    item_reg;
    turn_item_t                    item_next;

    wide_t              a_val;
    wide_t              b_val;
    logic [MAG_A_W-1:0] a_mag;
    logic [MAG_A_W-1:0] b_mag;
    logic [MAG_C_W-1:0] s_mag;
    logic [MAG_C_W-1:0] c_mag;
    logic               s_neg;
    logic               c_neg;
    logic signed [T_W:0] na_sum;
    logic signed [T_W:0] nb_sum;

    assign rdy2      = !valid2_reg || out_ready;
    assign rdy1      = !valid1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = valid2_reg;
    assign out_item  = item_reg;

    // The quadrant fold negates sine and cosine, which only flips their signs.
    always_comb
    begin
        a_val = $signed(in_item.v[0]);
        b_val = $signed(in_item.v[1]);
        a_mag = a_val[WIDE_W-1] ? MAG_A_W'(-a_val) : MAG_A_W'(a_val);
        b_mag = b_val[WIDE_W-1] ? MAG_A_W'(-b_val) : MAG_A_W'(b_val);
        s_neg = in_item.trig[0].sin_v[CS_W-1] ^ in_item.trig[0].flip;
        c_neg = in_item.trig[0].cos_v[CS_W-1] ^ in_item.trig[0].flip;
        s_mag = in_item.trig[0].sin_v[CS_W-1] ? MAG_C_W'(-in_item.trig[0].sin_v)
                                              : MAG_C_W'(in_item.trig[0].sin_v);
        c_mag = in_item.trig[0].cos_v[CS_W-1] ? MAG_C_W'(-in_item.trig[0].cos_v)
                                              : MAG_C_W'(in_item.trig[0].cos_v);

        prod_next[0] = PROD_W'(a_mag) * PROD_W'(c_mag);
        prod_next[1] = PROD_W'(b_mag) * PROD_W'(s_mag);
        prod_next[2] = PROD_W'(a_mag) * PROD_W'(s_mag);
        prod_next[3] = PROD_W'(b_mag) * PROD_W'(c_mag);
        neg_next[0]  = a_val[WIDE_W-1] ^ c_neg;
        neg_next[1]  = b_val[WIDE_W-1] ^ s_neg;
        neg_next[2]  = a_val[WIDE_W-1] ^ s_neg;
        neg_next[3]  = b_val[WIDE_W-1] ^ c_neg;
    end

    // The rotated pair is placed so that the next cell always turns the first two slots.
    always_comb
    begin
        na_sum = (T_W+1)'(round_term(prod_reg[0], neg_reg[0]))
               - (T_W+1)'(round_term(prod_reg[1], neg_reg[1]));
        nb_sum = (T_W+1)'(round_term(prod_reg[2], neg_reg[2]))
               + (T_W+1)'(round_term(prod_reg[3], neg_reg[3]));
        item_next         = pass_reg;
        item_next.v[0]    = wide_t'(nb_sum[WIDE_W-1:0]);
        item_next.v[1]    = pass_reg.v[2];
        item_next.v[2]    = wide_t'(na_sum[WIDE_W-1:0]);
        item_next.trig[0] = pass_reg.trig[1];
        item_next.trig[1] = pass_reg.trig[2];
        item_next.trig[2] = pass_reg.trig[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                valid1_reg <= in_valid;
            end
            if (rdy2)
            begin
                valid2_reg <= valid1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
            pass_reg <= in_item;
        end
        if (rdy2 && valid1_reg)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== design/euler_xyz_vector_rotation_core.sv =====
// Top level of the Euler x-then-y-then-z vector rotation core.
//
// The core rotates a signed Q16.16 vector about the x axis, then the y axis, then the
// z axis (result Rz*Ry*Rx*v) by three 16-bit binary angles, where 32768 stands for pi.
// It takes one vector per clock and gives one result per clock while the output is not
// stalled: a new beat may enter in every cycle. A beat passes 16 CORDIC cells that work
// out sine and cosine of all three angles side by side, three rotation cells of two stages
// each (one multiplier rank, then rounding and summing), and the output register. Every
// cell keeps its own valid bit and takes a new beat when it is empty or its neighbour
// moves on, so a stall on the output side is absorbed by any empty cells before the input
// stalls, and empty cells are squeezed out. Result components beyond the signed 32-bit
// range are clipped, and the saturated flag in m_tuser reports that any of them was.
module euler_xyz_vector_rotation_core
    import evr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // vec_x, vec_y, vec_z, angle_x, angle_y, angle_z, from the lowest bit up.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // rot_x, rot_y, rot_z, from the lowest bit up.
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // saturated.
    output logic                   m_tuser
);

    // Clips a wide component to the coordinate range; the top bit reports a clip.
    function automatic logic [COORD_WIDTH:0] clip_coord(input wide_t v);
        logic [WIDE_W-COORD_WIDTH:0] top_bits;
        top_bits = v[WIDE_W-1:COORD_WIDTH-1];
        if (top_bits == '0 || top_bits == '1)
        begin
            return {1'b0, v[COORD_WIDTH-1:0]};
        end
        else if (v[WIDE_W-1])
        begin
            return {2'b11, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            return {2'b10, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    cordic_item_t c_item  [CORDIC_STAGES+1];
    logic         c_valid [CORDIC_STAGES+1];
    logic         c_ready [CORDIC_STAGES+1];
    turn_item_t   t_item  [NUM_AXES+1];
    logic         t_valid [NUM_AXES+1];
    logic         t_ready [NUM_AXES+1];

    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic [OUT_TDATA_W-1:0] m_data_next;
    logic                   m_sat_reg;
    logic                   m_sat_next;
    logic                   out_en;

    // The vector travels in the order y, z, x so that each rotation cell turns its
    // first two slots; after three cells the order is y, z, x again.
    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++)
        begin : g_load
            logic [PHASE_W-1:0] phase;
            logic               flip;
            assign c_item[0].v[g] =
                WIDE_W'($signed(s_tdata[((g + 1) % NUM_AXES) * COORD_WIDTH +: COORD_WIDTH]));
            // Phases in the second and third quadrants are turned by half a turn and
            // the resulting sine and cosine negated later.
            assign phase = {s_tdata[NUM_AXES * COORD_WIDTH + g * ANGLE_WIDTH +: ANGLE_WIDTH],
                            {(PHASE_W - ANGLE_WIDTH){1'b0}}};
            assign flip  = phase[PHASE_W-1] ^ phase[PHASE_W-2];
            assign c_item[0].lane[g].x    = $signed(GAIN_START);
            assign c_item[0].lane[g].y    = '0;
            assign c_item[0].lane[g].z    =
                Z_W'($signed({phase[PHASE_W-1] ^ flip, phase[PHASE_W-2:0]}));
            assign c_item[0].lane[g].flip = flip;
        end
    endgenerate

    assign c_valid[0] = s_tvalid;
    assign s_tready   = c_ready[0];

    generate
        for (g = 0; g < CORDIC_STAGES; g++)
        begin : g_cordic
            evr_cordic_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .stage_idx (IDX_W'(g)),
                .in_valid  (c_valid[g]),
                .in_ready  (c_ready[g]),
                .in_item   (c_item[g]),
                .out_valid (c_valid[g+1]),
                .out_ready (c_ready[g+1]),
                .out_item  (c_item[g+1])
            );
        end
    endgenerate

    generate
        for (g = 0; g < NUM_AXES; g++)
        begin : g_trig
            assign t_item[0].v[g]          = c_item[CORDIC_STAGES].v[g];
            assign t_item[0].trig[g].sin_v = c_item[CORDIC_STAGES].lane[g].y;
            assign t_item[0].trig[g].cos_v = c_item[CORDIC_STAGES].lane[g].x;
            assign t_item[0].trig[g].flip  = c_item[CORDIC_STAGES].lane[g].flip;
        end
    endgenerate

    assign t_valid[0]             = c_valid[CORDIC_STAGES];
    assign c_ready[CORDIC_STAGES] = t_ready[0];

    generate
        for (g = 0; g < NUM_AXES; g++)
        begin : g_turn
            evr_turn_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (t_valid[g]),
                .in_ready  (t_ready[g]),
                .in_item   (t_item[g]),
                .out_valid (t_valid[g+1]),
                .out_ready (t_ready[g+1]),
                .out_item  (t_item[g+1])
            );
        end
    endgenerate

    // Output register: it takes a new result whenever the current one is gone or taken.
    assign out_en            = !m_valid_reg || m_tready;
    assign t_ready[NUM_AXES] = out_en;

    always_comb
    begin
        logic [COORD_WIDTH:0] cx;
        logic [COORD_WIDTH:0] cy;
        logic [COORD_WIDTH:0] cz;
        cx          = clip_coord(t_item[NUM_AXES].v[2]);
        cy          = clip_coord(t_item[NUM_AXES].v[0]);
        cz          = clip_coord(t_item[NUM_AXES].v[1]);
        m_data_next = OUT_TDATA_W'({cz[COORD_WIDTH-1:0], cy[COORD_WIDTH-1:0],
                                    cx[COORD_WIDTH-1:0]});
        m_sat_next  = cx[COORD_WIDTH] | cy[COORD_WIDTH] | cz[COORD_WIDTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            m_valid_reg <= t_valid[NUM_AXES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && t_valid[NUM_AXES])
        begin
            m_data_reg <= m_data_next;
            m_sat_reg  <= m_sat_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

endmodule
